@@ rtl/core/plp_pkg.sv @@
// plp_pkg: types, codes and constants shared by the profile lookup modules.
// No dependencies.
package plp_pkg;

  localparam int MAX_NODES = 64;
  localparam int CNT_W     = 7;
  localparam int IDX_W     = 6;
  localparam int DEPTH_W   = 24;
  localparam int SPEED_W   = 24;
  localparam int DENS_W    = 16;
  localparam int NUM_W     = 48;  // divider dividend magnitude
  localparam int PROD_W    = 50;  // signed product / quotient width

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_HINT  = 2'd1;
  localparam logic [1:0] CMD_SEG   = 2'd2;

  localparam logic [1:0] DIV_SPEED = 2'd0;
  localparam logic [1:0] DIV_GRAD  = 2'd1;
  localparam logic [1:0] DIV_DENS  = 2'd2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SEG_RANGE = 3'd1,
    ST_OUTSIDE   = 3'd2,
    ST_ZERO_LEN  = 3'd3,
    ST_BAD_IDX   = 3'd4,
    ST_SAT       = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [IDX_W-1:0]    node_index;
    logic [DEPTH_W-1:0]  node_depth;
    logic [SPEED_W-1:0]  node_speed;
    logic [DENS_W-1:0]   node_density;
    logic [DEPTH_W-1:0]  query_depth;
    logic [IDX_W-1:0]    segment_hint;
  } in_item_t;

  typedef struct packed {
    logic [SPEED_W-1:0]        sound_speed;
    logic signed [SPEED_W-1:0] speed_gradient;
    logic [DENS_W-1:0]         density;
    logic [IDX_W-1:0]          segment_index;
    status_t                   status;
  } out_item_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [SPEED_W-1:0] speed;
    logic [DENS_W-1:0]  dens;
  } node_t;

  typedef enum logic [2:0] {
    ADDR_NODE, ADDR_HINT, ADDR_HINT1, ADDR_FIRST,
    ADDR_LAST, ADDR_MID, ADDR_SEG, ADDR_SEG1
  } addr_sel_t;

  typedef enum logic [1:0] {SEG_HINT, SEG_FIRST, SEG_LAST, SEG_SEARCH} seg_sel_t;

  typedef enum logic [1:0] {FIN_ZERO, FIN_ERR, FIN_EVAL} fin_t;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_RD_H0, S_RD_H1, S_LD_H, S_HDEC,
    S_RD_F0, S_RD_L, S_LD_L, S_CDEC, S_SRCH, S_SWAIT,
    S_RD_S0, S_RD_S1, S_LD_S, S_EVAL, S_DSTART, S_DWAIT, S_DONE
  } state_t;

  typedef struct packed {
    logic      ld_in;
    logic      ram_we;
    addr_sel_t addr_sel;
    logic      ld_a;
    logic      ld_b;
    logic      seg_ld;
    seg_sel_t  seg_sel;
    logic      srch_init;
    logic      srch_step;
    logic      mul;
    logic      div_start;
    logic [1:0] div_sel;
    logic      quot_ld;
    logic      out_load;
    fin_t      fin;
    status_t   err;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       idx_bad;
    logic       hint_ok;
    logic       a_eq_b;
    logic       q_lt_a;
    logic       q_gt_b;
    logic       srch_more;
    logic       div_done;
    logic       out_free;
  } dp_stat_t;

endpackage

@@ rtl/core/plp_ram.sv @@
// plp_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module plp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/plp_div.sv @@
// plp_div: unsigned restoring divider, one quotient bit per cycle, with
// round-half-up flag. Depends on plp_pkg.
module plp_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [plp_pkg::NUM_W-1:0]    num,
  input  logic [plp_pkg::DEPTH_W-1:0]  den,
  output logic                         done,
  output logic [plp_pkg::NUM_W-1:0]    quot,
  output logic                         round_up
);
  import plp_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [NUM_W-1:0]  nq_r, nq_nxt;
  logic [DEPTH_W-1:0] rem_r, rem_nxt;
  logic [DEPTH_W-1:0] den_r, den_nxt;
  logic [DEPTH_W:0]  trial;
  logic              fits;

  assign trial = {rem_r, nq_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    nq_nxt   = nq_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NUM_W);
      nq_nxt   = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      // dividend bits shift out the top, quotient bits shift in below
      rem_nxt = fits ? DEPTH_W'(trial - {1'b0, den_r}) : DEPTH_W'(trial);
      nq_nxt  = {nq_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    nq_r  <= nq_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quot     = nq_r;
  assign round_up = {rem_r, 1'b0} >= {1'b0, den_r};

endmodule

@@ rtl/core/plp_dp.sv @@
// plp_dp: datapath of the profile lookup: node table, search bounds,
// products, shared divider, saturation and result register.
// Depends on plp_pkg, plp_ram, plp_div.
module plp_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  plp_pkg::in_item_t   in_data,
  input  logic                cfg_valid,
  input  logic [plp_pkg::CNT_W-1:0] cfg_data,
  input  logic                out_ready,
  output logic                out_valid,
  output plp_pkg::out_item_t  out_data,
  input  plp_pkg::ctrl_cmd_t  cmd,
  output plp_pkg::dp_stat_t   stat
);
  import plp_pkg::*;

  in_item_t   item_r;
  logic [CNT_W-1:0] ncnt_r;
  node_t      a_r, b_r, rdata;
  logic [IDX_W-1:0] raddr, seg_r, seg_nxt;
  logic [CNT_W-1:0] lo_r, hi_r, mid, n_act, segs, lo_m1;
  logic signed [DEPTH_W:0] dd, off, ds;
  logic signed [DENS_W:0]  dr;
  logic signed [PROD_W-1:0] p_sp_r, p_dn_r, num_s, qmag_s, q_s;
  logic signed [32:0]       p_gr_r;
  logic signed [PROD_W-1:0] q_sp_r, q_gr_r, q_dn_r;
  logic [DEPTH_W-1:0] ud;
  logic [NUM_W-1:0]   num_mag, quot;
  logic               neg_r, div_done, round_up;
  logic signed [PROD_W:0] sp_sum, dn_sum;
  logic [SPEED_W-1:0] sp_sat;
  logic signed [SPEED_W-1:0] gr_sat;
  logic [DENS_W-1:0]  dn_sat;
  logic               sat_any;
  out_item_t          out_r, out_nxt;
  logic               out_valid_r;

  // active node count clamped to the table
  always_comb begin
    if (ncnt_r < CNT_W'(2))              n_act = CNT_W'(2);
    else if (ncnt_r > CNT_W'(MAX_NODES)) n_act = CNT_W'(MAX_NODES);
    else                                 n_act = ncnt_r;
  end
  assign segs  = n_act - CNT_W'(1);
  assign mid   = lo_r + ((hi_r - lo_r) >> 1);
  assign lo_m1 = lo_r - CNT_W'(1);

  always_comb begin
    unique case (cmd.addr_sel)
      ADDR_NODE:  raddr = item_r.node_index;
      ADDR_HINT:  raddr = item_r.segment_hint;
      ADDR_HINT1: raddr = item_r.segment_hint + IDX_W'(1);
      ADDR_FIRST: raddr = '0;
      ADDR_LAST:  raddr = IDX_W'(n_act - CNT_W'(1));
      ADDR_MID:   raddr = mid[IDX_W-1:0];
      ADDR_SEG:   raddr = seg_r;
      ADDR_SEG1:  raddr = seg_r + IDX_W'(1);
      default:    raddr = '0;
    endcase
  end

  plp_ram #(.WIDTH($bits(node_t)), .DEPTH(MAX_NODES)) u_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (item_r.node_index),
    .wdata ({item_r.node_depth, item_r.node_speed, item_r.node_density}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    unique case (cmd.seg_sel)
      SEG_HINT:  seg_nxt = item_r.segment_hint;
      SEG_FIRST: seg_nxt = '0;
      SEG_LAST:  seg_nxt = IDX_W'(segs - CNT_W'(1));
      SEG_SEARCH: begin
        if (lo_r == '0)                    seg_nxt = '0;
        else if (lo_m1 < segs - CNT_W'(1)) seg_nxt = IDX_W'(lo_m1);
        else                               seg_nxt = IDX_W'(segs - CNT_W'(1));
      end
      default:   seg_nxt = '0;
    endcase
  end

  assign dd  = $signed({1'b0, b_r.depth}) - $signed({1'b0, a_r.depth});
  assign off = $signed({1'b0, item_r.query_depth}) - $signed({1'b0, a_r.depth});
  assign ds  = $signed({1'b0, b_r.speed}) - $signed({1'b0, a_r.speed});
  assign dr  = $signed({1'b0, b_r.dens}) - $signed({1'b0, a_r.dens});
  assign ud  = dd[DEPTH_W] ? DEPTH_W'(-dd) : DEPTH_W'(dd);

  always_comb begin
    unique case (cmd.div_sel)
      DIV_SPEED: num_s = p_sp_r;
      DIV_GRAD:  num_s = PROD_W'(p_gr_r);
      DIV_DENS:  num_s = p_dn_r;
      default:   num_s = '0;
    endcase
  end
  assign num_mag = num_s[PROD_W-1] ? NUM_W'(-num_s) : NUM_W'(num_s);

  plp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .num      (num_mag),
    .den      (ud),
    .done     (div_done),
    .quot     (quot),
    .round_up (round_up)
  );

  assign qmag_s = $signed(PROD_W'(quot)) + $signed(PROD_W'(round_up));
  assign q_s    = neg_r ? -qmag_s : qmag_s;

  // final sums and saturation
  assign sp_sum = $signed({27'd0, a_r.speed}) + (PROD_W+1)'(q_sp_r);
  assign dn_sum = $signed({35'd0, a_r.dens}) + (PROD_W+1)'(q_dn_r);

  always_comb begin
    sat_any = 1'b0;
    if (sp_sum < 0) begin
      sp_sat = '0; sat_any = 1'b1;
    end else if (sp_sum > $signed((PROD_W+1)'({SPEED_W{1'b1}}))) begin
      sp_sat = '1; sat_any = 1'b1;
    end else begin
      sp_sat = sp_sum[SPEED_W-1:0];
    end
    if (q_gr_r < -$signed(PROD_W'(8388608))) begin
      gr_sat = -24'sd8388608; sat_any = 1'b1;
    end else if (q_gr_r > $signed(PROD_W'(8388607))) begin
      gr_sat = 24'sd8388607; sat_any = 1'b1;
    end else begin
      gr_sat = q_gr_r[SPEED_W-1:0];
    end
    if (dn_sum < 0) begin
      dn_sat = '0; sat_any = 1'b1;
    end else if (dn_sum > $signed((PROD_W+1)'({DENS_W{1'b1}}))) begin
      dn_sat = '1; sat_any = 1'b1;
    end else begin
      dn_sat = dn_sum[DENS_W-1:0];
    end
  end

  always_comb begin
    out_nxt = '0;
    unique case (cmd.fin)
      FIN_ZERO: out_nxt.status = cmd.err;
      FIN_ERR: begin
        out_nxt.segment_index = seg_r;
        out_nxt.status        = cmd.err;
      end
      FIN_EVAL: begin
        out_nxt.sound_speed    = sp_sat;
        out_nxt.speed_gradient = gr_sat;
        out_nxt.density        = dn_sat;
        out_nxt.segment_index  = seg_r;
        out_nxt.status         = sat_any ? ST_SAT : ST_OK;
      end
      default: out_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncnt_r      <= CNT_W'(2);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) ncnt_r <= cfg_data;
      if (cmd.out_load)                out_valid_r <= 1'b1;
      else if (out_ready)              out_valid_r <= 1'b0;
    end
    if (cmd.ld_in)    item_r <= in_data;
    if (cmd.ld_a)     a_r <= rdata;
    if (cmd.ld_b)     b_r <= rdata;
    if (cmd.seg_ld)   seg_r <= seg_nxt;
    if (cmd.srch_init) begin
      lo_r <= '0;
      hi_r <= n_act;
    end else if (cmd.srch_step) begin
      // lower-bound step on the node read at mid
      if (rdata.depth < item_r.query_depth) lo_r <= mid + CNT_W'(1);
      else                                  hi_r <= mid;
    end
    if (cmd.mul) begin
      p_sp_r <= PROD_W'(off) * PROD_W'(ds);
      p_gr_r <= 33'(ds) <<< 8;
      p_dn_r <= PROD_W'(off) * PROD_W'(dr);
    end
    if (cmd.div_start) neg_r <= num_s[PROD_W-1] ^ dd[DEPTH_W];
    if (cmd.quot_ld) begin
      unique case (cmd.div_sel)
        DIV_SPEED: q_sp_r <= q_s;
        DIV_GRAD:  q_gr_r <= q_s;
        DIV_DENS:  q_dn_r <= q_s;
        default:   q_sp_r <= q_s;
      endcase
    end
    if (cmd.out_load) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign stat.cmd       = item_r.cmd;
  assign stat.idx_bad   = {1'b0, item_r.node_index} >= CNT_W'(MAX_NODES);
  assign stat.hint_ok   = {1'b0, item_r.segment_hint} < segs;
  assign stat.a_eq_b    = a_r.depth == b_r.depth;
  assign stat.q_lt_a    = item_r.query_depth < a_r.depth;
  assign stat.q_gt_b    = item_r.query_depth > b_r.depth;
  assign stat.srch_more = lo_r < hi_r;
  assign stat.div_done  = div_done;
  assign stat.out_free  = !out_valid_r || out_ready;

endmodule

@@ rtl/core/plp_ctrl.sv @@
// plp_ctrl: sequencer of the profile lookup: hint test, clamp, binary
// search, segment fetch and divider sequence. Depends on plp_pkg.
module plp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  plp_pkg::dp_stat_t  stat,
  output plp_pkg::ctrl_cmd_t cmd
);
  import plp_pkg::*;

  state_t     state_r, state_nxt;
  fin_t       fin_r, fin_nxt;
  status_t    err_r, err_nxt;
  logic [1:0] dsel_r, dsel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_r   <= FIN_ZERO;
      err_r   <= ST_OK;
      dsel_r  <= DIV_SPEED;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
      err_r   <= err_nxt;
      dsel_r  <= dsel_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    fin_nxt      = fin_r;
    err_nxt      = err_r;
    dsel_nxt     = dsel_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.addr_sel = ADDR_NODE;
    cmd.seg_sel  = SEG_HINT;
    cmd.div_sel  = dsel_r;
    cmd.fin      = fin_r;
    cmd.err      = err_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.seg_ld = 1'b1;
        fin_nxt    = FIN_ZERO;
        err_nxt    = ST_OK;
        unique case (stat.cmd)
          CMD_WRITE: begin
            if (stat.idx_bad) err_nxt = ST_BAD_IDX;
            else              cmd.ram_we = 1'b1;
            state_nxt = S_DONE;
          end
          CMD_HINT: state_nxt = stat.hint_ok ? S_RD_H0 : S_RD_F0;
          CMD_SEG: begin
            if (stat.hint_ok) begin
              state_nxt = S_RD_H0;
            end else begin
              fin_nxt   = FIN_ERR;
              err_nxt   = ST_SEG_RANGE;
              state_nxt = S_DONE;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_RD_H0: begin
        cmd.addr_sel = ADDR_HINT;
        state_nxt    = S_RD_H1;
      end
      S_RD_H1: begin
        cmd.addr_sel = ADDR_HINT1;
        cmd.ld_a     = 1'b1;
        state_nxt    = S_LD_H;
      end
      S_LD_H: begin
        cmd.ld_b  = 1'b1;
        state_nxt = S_HDEC;
      end
      S_HDEC: begin
        if (stat.cmd == CMD_SEG) begin
          if (stat.a_eq_b) begin
            fin_nxt = FIN_ERR; err_nxt = ST_ZERO_LEN; state_nxt = S_DONE;
          end else if (stat.q_lt_a || stat.q_gt_b) begin
            fin_nxt = FIN_ERR; err_nxt = ST_OUTSIDE; state_nxt = S_DONE;
          end else begin
            state_nxt = S_EVAL;
          end
        end else begin
          state_nxt = (!stat.q_lt_a && !stat.q_gt_b) ? S_EVAL : S_RD_F0;
        end
      end
      S_RD_F0: begin
        cmd.addr_sel = ADDR_FIRST;
        state_nxt    = S_RD_L;
      end
      S_RD_L: begin
        cmd.addr_sel = ADDR_LAST;
        cmd.ld_a     = 1'b1;
        state_nxt    = S_LD_L;
      end
      S_LD_L: begin
        cmd.ld_b  = 1'b1;
        state_nxt = S_CDEC;
      end
      S_CDEC: begin
        // a holds the first node, b the last
        if (stat.q_lt_a) begin
          cmd.seg_ld = 1'b1; cmd.seg_sel = SEG_FIRST; state_nxt = S_RD_S0;
        end else if (stat.q_gt_b) begin
          cmd.seg_ld = 1'b1; cmd.seg_sel = SEG_LAST; state_nxt = S_RD_S0;
        end else begin
          cmd.srch_init = 1'b1;
          state_nxt     = S_SRCH;
        end
      end
      S_SRCH: begin
        if (stat.srch_more) begin
          cmd.addr_sel = ADDR_MID;
          state_nxt    = S_SWAIT;
        end else begin
          cmd.seg_ld  = 1'b1;
          cmd.seg_sel = SEG_SEARCH;
          state_nxt   = S_RD_S0;
        end
      end
      S_SWAIT: begin
        cmd.addr_sel  = ADDR_MID;
        cmd.srch_step = 1'b1;
        state_nxt     = S_SRCH;
      end
      S_RD_S0: begin
        cmd.addr_sel = ADDR_SEG;
        state_nxt    = S_RD_S1;
      end
      S_RD_S1: begin
        cmd.addr_sel = ADDR_SEG1;
        cmd.ld_a     = 1'b1;
        state_nxt    = S_LD_S;
      end
      S_LD_S: begin
        cmd.ld_b  = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (stat.a_eq_b) begin
          fin_nxt = FIN_ERR; err_nxt = ST_ZERO_LEN; state_nxt = S_DONE;
        end else begin
          cmd.mul   = 1'b1;
          dsel_nxt  = DIV_SPEED;
          state_nxt = S_DSTART;
        end
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (stat.div_done) begin
          cmd.quot_ld = 1'b1;
          if (dsel_r == DIV_DENS) begin
            fin_nxt   = FIN_EVAL;
            err_nxt   = ST_OK;
            state_nxt = S_DONE;
          end else begin
            dsel_nxt  = dsel_r + 2'd1;
            state_nxt = S_DSTART;
          end
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/piecewise_linear_profile_lookup.sv @@
// Piecewise-linear sound speed / density profile lookup, top level.
// Holds a 64-node table, one write or query item at a time, one result each.
//   in_*  : item with cmd, node fields, query depth and segment hint;
//           in_ready is high only while the block is idle.
//   out_* : one result per item, held in an output register until taken.
//   cfg_* : node_count write, always ready; write only while idle.
// Steps from the input transfer to the raising of out_valid:
//   node write or unused cmd: the start state, then the result load
//   forced segment error: at once if out of range, else after the hint reads
//   evaluation: the shared one-bit-per-cycle divider runs three 48-bit
//     divisions in turn (speed, gradient, density); a hint miss adds the
//     first/last node reads and the segment fetch, and a binary search
//     of up to 7 steps when the query lies inside the first and last node
// A new item is taken only once the last result is loaded; while the result
// register is full and out_ready is low the sequencer waits in its last
// state, so no item is lost. Reset clears the sequencer, the output valid
// and sets node_count to 2; the table is not cleared and holds whatever
// was written last.
// Depends on plp_pkg, plp_ctrl, plp_dp.
module piecewise_linear_profile_lookup (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  plp_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output plp_pkg::out_item_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [plp_pkg::CNT_W-1:0]    cfg_data
);
  import plp_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  plp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  plp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

@@ rtl/core/plp_chk.sv @@
// plp_chk: port-level checks of the profile lookup, bound to the top level.
// Depends on plp_pkg and piecewise_linear_profile_lookup.
module plp_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input plp_pkg::out_item_t        out_data
);
  import plp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item in flight: busy right after a transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again before finishing");

  // a new result only comes from an item being worked on
  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a pending item");

  // error results carry zero values
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK && out_data.status != ST_SAT |->
      out_data.sound_speed == '0 && out_data.speed_gradient == '0 &&
      out_data.density == '0)
    else $error("error result with nonzero values");

endmodule

bind piecewise_linear_profile_lookup plp_chk u_plp_chk (.*);
